### sv/anfg_pkg.sv
// Shared types and constants of the analog noise floor generator.
package anfg_pkg;

  localparam int unsigned SineTableDepthDef = 256;
  localparam int unsigned PhaseBitsDef      = 24;
  localparam int unsigned SampleBitsDef     = 24;

  // register map
  typedef enum logic [2:0] {
    CFG_GAIN_TARGET  = 3'd0,
    CFG_RAMP_LENGTH  = 3'd1,
    CFG_HUM_INC      = 3'd2,
    CFG_WHIR_INC     = 3'd3,
    CFG_WHIR_AM_INC  = 3'd4,
    CFG_AGE_LEVEL    = 3'd5,
    CFG_RNG_SEED     = 3'd6
  } cfg_idx_e;

  localparam logic [23:0] GainTargetRst = 24'd16777;
  localparam logic [15:0] RampLengthRst = 16'd960;
  localparam logic [23:0] HumIncRst     = 24'd20972;
  localparam logic [23:0] WhirIncRst    = 24'd62915;
  localparam logic [23:0] WhirAmIncRst  = 24'd105;
  localparam logic [15:0] AgeLevelRst   = 16'd0;
  localparam logic [31:0] RngSeedRst    = 32'd1;

  localparam logic [31:0] LcgMul = 32'd1664525;
  localparam logic [31:0] LcgAdd = 32'd1013904223;

  // signed Q1.24 coefficients
  localparam logic signed [25:0] KSlowPole = 26'sd16737790;
  localparam logic signed [25:0] KSlowIn   = 26'sd1661716;
  localparam logic signed [25:0] KMidPole  = 26'sd16156459;
  localparam logic signed [25:0] KMidIn    = 26'sd4974720;
  localparam logic signed [25:0] KFastPole = 26'sd9563013;
  localparam logic signed [25:0] KFastIn   = 26'sd17661229;
  localparam logic signed [25:0] KDirect   = 26'sd3100430;
  localparam logic signed [25:0] KPinkOut  = 26'sd3690988;
  localparam logic signed [25:0] KHarm2    = 26'sd6710886;
  localparam logic signed [25:0] KHarm3    = 26'sd2516582;
  localparam logic signed [25:0] KHum      = 26'sd4194;
  localparam logic signed [35:0] KWhir     = 36'sd5033;

  localparam logic [63:0] OneQ30    = 64'd1 << 30;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] Q23Max    = 64'd8388607;

  typedef struct packed {
    logic [23:0] gain_target;
    logic [15:0] ramp_length;
    logic [23:0] hum_inc;
    logic [23:0] whir_inc;
    logic [23:0] whir_am_inc;
    logic [15:0] age_level;
    logic [31:0] rng_seed;
    logic        seed_load;
  } anfg_cfg_t;

endpackage

### sv/anfg_front.sv
// Input side: accepts beats and holds them in a two-entry queue for the engine.
module anfg_front import anfg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic in_clear_i,
  output logic q_valid_o,
  output logic q_clear_o,
  input  logic q_pop_i
);

  logic [1:0] ent_q, ent_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, wp_d, rp_q, rp_d;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_clear_o  = ent_q[rp_q];

  always_comb begin
    ent_d = ent_q;
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      ent_d[wp_q] = in_clear_i;
      wp_d        = ~wp_q;
    end
    if (q_pop_i) begin
      rp_d = ~rp_q;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      ent_q <= ent_d;
      cnt_q <= cnt_d;
      wp_q  <= wp_d;
      rp_q  <= rp_d;
    end
  end

endmodule

### sv/anfg_div.sv
// Radix-2 restoring divider for the gain ramp step, truncating toward zero.
module anfg_div import anfg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [24:0] num_i,
  input  logic        [15:0] den_i,
  output logic               busy_o,
  output logic signed [24:0] quo_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] rem_q, rem_d;
  logic [23:0] mag_q, mag_d;
  logic [15:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [16:0] rem_sh;
  logic [24:0] abs_num;

  assign abs_num = num_i[24] ? -num_i : num_i;
  assign rem_sh  = {rem_q[15:0], mag_q[23]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    mag_d  = mag_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd24;
      rem_d  = '0;
      mag_d  = abs_num[23:0];
      den_d  = den_i;
      neg_d  = num_i[24];
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        mag_d = {mag_q[22:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        mag_d = {mag_q[22:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    mag_q <= mag_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

### sv/anfg_back.sv
// Sample engine: gain ramp control, pink filter, hum and whir on one shared multiplier.
module anfg_back import anfg_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SineTableDepthDef,
  parameter int unsigned PHASE_BITS       = PhaseBitsDef,
  parameter int unsigned SAMPLE_BITS      = SampleBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  anfg_cfg_t              cfg_i,
  input  logic                   q_valid_i,
  input  logic                   q_clear_i,
  output logic                   q_pop_o,
  output logic                   div_start_o,
  output logic signed [24:0]     div_num_o,
  input  logic                   div_busy_i,
  input  logic signed [24:0]     div_quo_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] out_data_o
);

  localparam int unsigned AW   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned IW   = (PHASE_BITS > 24) ? PHASE_BITS : 24;
  localparam int unsigned UP   = (SAMPLE_BITS >= 24) ? SAMPLE_BITS - 24 : 0;
  localparam int unsigned DOWN = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
  localparam logic [4:0]  LastStep = 5'd21;

  typedef logic signed [23:0] tab_t [SINE_TABLE_DEPTH];

  function automatic logic signed [23:0] quarter_sine(input logic [63:0] m);
    logic [63:0] x, x2, t, r;
    x  = (HalfPiQ30 * m) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t  = OneQ30;
    t  = OneQ30 - ((x2 * t) >> 30) / 110;
    t  = OneQ30 - ((x2 * t) >> 30) / 72;
    t  = OneQ30 - ((x2 * t) >> 30) / 42;
    t  = OneQ30 - ((x2 * t) >> 30) / 20;
    t  = OneQ30 - ((x2 * t) >> 30) / 6;
    r  = (((x * t) >> 30) + 64) >> 7;
    if (r > Q23Max) begin
      r = Q23Max;
    end
    return r[23:0];
  endfunction

  function automatic tab_t build_tab();
    tab_t tb;
    logic [63:0] u, q, rr;
    logic signed [23:0] v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      u  = 64'(4 * i);
      q  = u / SINE_TABLE_DEPTH;
      rr = u % SINE_TABLE_DEPTH;
      v  = quarter_sine(q[0] ? 64'(SINE_TABLE_DEPTH) - rr : rr);
      tb[i] = (q >= 2) ? -v : v;
    end
    return tb;
  endfunction

  localparam tab_t SineRom = build_tab();

  // round half up, then floor shift
  function automatic logic signed [61:0] rnd(input logic signed [61:0] p, input int unsigned s);
    logic signed [61:0] tmp;
    tmp = p + (62'sd1 <<< (s - 1));
    return tmp >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  typedef enum logic [2:0] {S_IDLE, S_GOAL, S_DIV, S_DISP, S_RUN, S_OUT} state_e;

  state_e state_q, state_d;
  logic [4:0]  step_q, step_d;
  logic        clr_q, clr_d;

  logic [31:0] lcg_q, lcg_d;
  logic signed [31:0] slow_q, slow_d, mid_q, mid_d, fast_q, fast_d;
  logic [PHASE_BITS-1:0] hum_ph_q, hum_ph_d, whir_ph_q, whir_ph_d, am_ph_q, am_ph_d;
  logic [23:0] gain_q, gain_d, seen_q, seen_d;
  logic signed [24:0] gstep_q, gstep_d;
  logic [15:0] ramp_q, ramp_d;
  logic        ov_q, ov_d;
  logic [SAMPLE_BITS-1:0] od_q, od_d;

  // datapath, no reset
  logic signed [61:0] prod_q;
  logic signed [23:0] rom_q, s_h1_q, s_h2_q, s_h3_q, s_am_q, s_w_q;
  logic signed [35:0] acc_q, acc_d;
  logic signed [39:0] tot_q, tot_d;

  logic signed [35:0] mul_a;
  logic signed [25:0] mul_b;
  logic [PHASE_BITS-1:0] rd_ph;
  logic [PHASE_BITS+AW-1:0] idx_prod;
  logic [AW-1:0] idx;
  logic signed [23:0] white;
  logic signed [61:0] pr24;
  logic signed [37:0] psum;
  logic signed [25:0] gsum;
  logic [15:0] rl_dec;
  logic signed [35:0] am_val;
  logic signed [47:0] scaled;
  logic signed [47:0] smax;

  // (2*w - 65535) * 128
  assign white    = 24'($signed({1'b0, lcg_q[23:8], 8'd0}) - 25'sd8388480);
  assign pr24     = rnd(prod_q, 24);
  assign idx_prod = (PHASE_BITS + AW)'(rd_ph) * (PHASE_BITS + AW)'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[PHASE_BITS+AW-1:PHASE_BITS];
  assign am_val   = (36'sd8388608 + 36'(s_am_q)) >>> 1;
  assign scaled   = (48'(tot_q) <<< UP) >>> DOWN;
  assign smax     = (48'sd1 <<< (SAMPLE_BITS - 1)) - 48'sd1;
  assign rl_dec   = ramp_q - 16'd1;
  assign gsum     = 26'($signed({1'b0, gain_q})) + 26'(gstep_q);
  assign div_num_o = $signed({1'b0, cfg_i.gain_target}) - $signed({1'b0, gain_q});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    clr_d   = clr_q;
    lcg_d   = lcg_q;
    slow_d  = slow_q;
    mid_d   = mid_q;
    fast_d  = fast_q;
    hum_ph_d  = hum_ph_q;
    whir_ph_d = whir_ph_q;
    am_ph_d   = am_ph_q;
    gain_d  = gain_q;
    seen_d  = seen_q;
    gstep_d = gstep_q;
    ramp_d  = ramp_q;
    ov_d    = ov_q;
    od_d    = od_q;
    acc_d   = acc_q;
    tot_d   = tot_q;
    mul_a   = '0;
    mul_b   = '0;
    rd_ph   = hum_ph_q;
    psum    = '0;
    q_pop_o = 1'b0;
    div_start_o = 1'b0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          clr_d   = q_clear_i;
          state_d = S_GOAL;
        end
      end
      S_GOAL: begin
        state_d = S_DISP;
        if (cfg_i.gain_target != seen_q) begin
          seen_d = cfg_i.gain_target;
          if (cfg_i.ramp_length == 16'd0) begin
            gain_d  = cfg_i.gain_target;
            ramp_d  = '0;
            gstep_d = '0;
          end else begin
            ramp_d      = cfg_i.ramp_length;
            div_start_o = 1'b1;
            state_d     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!div_busy_i) begin
          gstep_d = div_quo_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (clr_q) begin
          slow_d = '0;
          mid_d  = '0;
          fast_d = '0;
          hum_ph_d  = '0;
          whir_ph_d = '0;
          am_ph_d   = '0;
          gain_d  = seen_q;
          ramp_d  = '0;
          gstep_d = '0;
          state_d = S_IDLE;
        end else begin
          step_d  = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        step_d = step_q + 5'd1;
        case (step_q)
          5'd0: begin
            mul_a = 36'(lcg_q);
            mul_b = 26'(LcgMul);
            rd_ph = hum_ph_q;
          end
          5'd1: begin
            lcg_d = prod_q[31:0] + LcgAdd;
            rd_ph = {hum_ph_q[PHASE_BITS-2:0], 1'b0};
            mul_a = 36'(slow_q);
            mul_b = KSlowPole;
          end
          5'd2: begin
            acc_d = 36'(pr24);
            rd_ph = PHASE_BITS'(hum_ph_q * 2'd3);
            mul_a = 36'(white);
            mul_b = KSlowIn;
          end
          5'd3: begin
            psum   = 38'(acc_q) + 38'(pr24);
            slow_d = sat32(psum);
            rd_ph  = am_ph_q;
            mul_a  = 36'(mid_q);
            mul_b  = KMidPole;
          end
          5'd4: begin
            acc_d = 36'(pr24);
            rd_ph = whir_ph_q;
            mul_a = 36'(white);
            mul_b = KMidIn;
          end
          5'd5: begin
            psum  = 38'(acc_q) + 38'(pr24);
            mid_d = sat32(psum);
            mul_a = 36'(fast_q);
            mul_b = KFastPole;
          end
          5'd6: begin
            acc_d = 36'(pr24);
            mul_a = 36'(white);
            mul_b = KFastIn;
          end
          5'd7: begin
            psum   = 38'(acc_q) + 38'(pr24);
            fast_d = sat32(psum);
            mul_a  = 36'(white);
            mul_b  = KDirect;
          end
          5'd8: begin
            acc_d = 36'(slow_q) + 36'(mid_q) + 36'(fast_q) + 36'(pr24);
            if (ramp_q != 16'd0) begin
              ramp_d = rl_dec;
              if (rl_dec != 16'd0) begin
                if (gsum < 26'sd0) begin
                  gain_d = '0;
                end else if (gsum > 26'sd16777215) begin
                  gain_d = 24'hffffff;
                end else begin
                  gain_d = gsum[23:0];
                end
              end else begin
                gain_d = seen_q;
              end
            end else begin
              gain_d = seen_q;
            end
          end
          5'd9: begin
            mul_a = acc_q;
            mul_b = KPinkOut;
          end
          5'd10: begin
            acc_d = 36'(pr24);
          end
          5'd11: begin
            mul_a = acc_q;
            mul_b = $signed({2'b00, gain_q});
          end
          5'd12: begin
            tot_d = 40'(pr24);
            mul_a = 36'(s_h2_q);
            mul_b = KHarm2;
          end
          5'd13: begin
            acc_d = 36'(s_h1_q) + 36'(pr24);
            mul_a = 36'(s_h3_q);
            mul_b = KHarm3;
          end
          5'd14: begin
            acc_d = acc_q + 36'(pr24);
          end
          5'd15: begin
            mul_a = acc_q;
            mul_b = KHum;
          end
          5'd16: begin
            tot_d = tot_q + 40'(pr24);
            mul_a = KWhir;
            mul_b = 26'sd65536 + $signed({10'd0, cfg_i.age_level});
          end
          5'd17: begin
            acc_d = 36'(rnd(prod_q, 16));
          end
          5'd18: begin
            mul_a = am_val;
            mul_b = acc_q[25:0];
          end
          5'd19: begin
            acc_d = 36'(pr24);
          end
          5'd20: begin
            mul_a = acc_q;
            mul_b = 26'(s_w_q);
          end
          default: begin
            tot_d = tot_q + 40'(rnd(prod_q, 23));
            hum_ph_d  = PHASE_BITS'(IW'(hum_ph_q) + IW'(cfg_i.hum_inc));
            whir_ph_d = PHASE_BITS'(IW'(whir_ph_q) + IW'(cfg_i.whir_inc));
            am_ph_d   = PHASE_BITS'(IW'(am_ph_q) + IW'(cfg_i.whir_am_inc));
          end
        endcase
        if (step_q == LastStep) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          if (scaled > smax) begin
            od_d = smax[SAMPLE_BITS-1:0];
          end else if (scaled < -smax - 48'sd1) begin
            od_d = SAMPLE_BITS'(-smax - 48'sd1);
          end else begin
            od_d = scaled[SAMPLE_BITS-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_i.seed_load) begin
      lcg_d = cfg_i.rng_seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      clr_q     <= 1'b0;
      lcg_q     <= RngSeedRst;
      slow_q    <= '0;
      mid_q     <= '0;
      fast_q    <= '0;
      hum_ph_q  <= '0;
      whir_ph_q <= '0;
      am_ph_q   <= '0;
      gain_q    <= GainTargetRst;
      seen_q    <= GainTargetRst;
      gstep_q   <= '0;
      ramp_q    <= '0;
      ov_q      <= 1'b0;
      od_q      <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      clr_q     <= clr_d;
      lcg_q     <= lcg_d;
      slow_q    <= slow_d;
      mid_q     <= mid_d;
      fast_q    <= fast_d;
      hum_ph_q  <= hum_ph_d;
      whir_ph_q <= whir_ph_d;
      am_ph_q   <= am_ph_d;
      gain_q    <= gain_d;
      seen_q    <= seen_d;
      gstep_q   <= gstep_d;
      ramp_q    <= ramp_d;
      ov_q      <= ov_d;
      od_q      <= od_d;
    end
  end

  // sine reads are registered and land in the step after the phase is chosen
  always_ff @(posedge clk_i) begin
    prod_q <= 62'(mul_a * mul_b);
    rom_q  <= SineRom[idx];
    acc_q  <= acc_d;
    tot_q  <= tot_d;
    if (state_q == S_RUN) begin
      case (step_q)
        5'd1:    s_h1_q <= rom_q;
        5'd2:    s_h2_q <= rom_q;
        5'd3:    s_h3_q <= rom_q;
        5'd4:    s_am_q <= rom_q;
        5'd5:    s_w_q  <= rom_q;
        default: ;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

### sv/analog_noise_floor_generator.sv
// Top level of the analog noise floor generator: registers, queue, divider and engine.
// Each beat on the input stream either produces one audio sample (clear flag low) or clears
// the pink filter and oscillator phases and snaps the hiss gain to its target (clear flag
// high, no output beat). A sample goes from the queue to the output register in order: the
// engine takes the beat from the queue, checks the gain target, dispatches, runs 22 steps of
// the single shared multiplier, which computes the random generator, the three filter poles,
// the gain and the hum and whir products in turn, and loads the output register once any
// previous result has been taken. On a gain target change with a nonzero ramp length it also
// waits for the bit-serial divider sizing the ramp step. A clear beat ends at dispatch. A
// two-entry queue takes beats while the engine works and a result waits in the output
// register. Configuration writes are taken in any cycle; writing rng_seed also reloads the
// generator state. The sine table is a ROM with a registered read.
module analog_noise_floor_generator import anfg_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SineTableDepthDef,
  parameter int unsigned PHASE_BITS       = PhaseBitsDef,
  parameter int unsigned SAMPLE_BITS      = SampleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] clear_state
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // [SAMPLE_BITS-1:0] sample_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned OutW = ((SAMPLE_BITS + 7) / 8) * 8;

  anfg_cfg_t cfg;
  logic [23:0] gain_target_q, hum_inc_q, whir_inc_q, am_inc_q;
  logic [15:0] ramp_len_q, age_q;
  logic        cfg_wr;

  logic        q_valid, q_clear, q_pop;
  logic        div_start, div_busy;
  logic signed [24:0] div_num, div_quo;
  logic [SAMPLE_BITS-1:0] sample;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_target_q <= GainTargetRst;
      ramp_len_q    <= RampLengthRst;
      hum_inc_q     <= HumIncRst;
      whir_inc_q    <= WhirIncRst;
      am_inc_q      <= WhirAmIncRst;
      age_q         <= AgeLevelRst;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_GAIN_TARGET: gain_target_q <= cfg_data_i[23:0];
        CFG_RAMP_LENGTH: ramp_len_q    <= cfg_data_i[15:0];
        CFG_HUM_INC:     hum_inc_q     <= cfg_data_i[23:0];
        CFG_WHIR_INC:    whir_inc_q    <= cfg_data_i[23:0];
        CFG_WHIR_AM_INC: am_inc_q      <= cfg_data_i[23:0];
        CFG_AGE_LEVEL:   age_q         <= cfg_data_i[15:0];
        // seed goes straight into the generator state
        CFG_RNG_SEED:    ;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.gain_target = gain_target_q;
    cfg.ramp_length = ramp_len_q;
    cfg.hum_inc     = hum_inc_q;
    cfg.whir_inc    = whir_inc_q;
    cfg.whir_am_inc = am_inc_q;
    cfg.age_level   = age_q;
    cfg.rng_seed    = cfg_data_i;
    cfg.seed_load   = cfg_wr && (cfg_index_i == CFG_RNG_SEED);
  end

  anfg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_clear_i (s_axis_tdata[0]),
    .q_valid_o  (q_valid),
    .q_clear_o  (q_clear),
    .q_pop_i    (q_pop)
  );

  anfg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (ramp_len_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  anfg_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_clear_i   (q_clear),
    .q_pop_o     (q_pop),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_busy_i  (div_busy),
    .div_quo_i   (div_quo),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (sample)
  );

  assign m_axis_tdata = OutW'(sample);

  // engine only pops a queued beat
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");

  // divider is never restarted mid-division
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");

  // a started division is reported busy on the next cycle
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_busy) else $error("divider did not start");

endmodule

### verif/tb_top.sv
// Self-checking testbench for the analog noise floor generator: stream stimulus and a scoreboard.
module tb_top import anfg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RomDepth = SineTableDepthDef;
  localparam logic [2:0] CfgUnused = 3'd7;
  localparam logic [7:0] ItemMake  = 8'h00;
  localparam logic [7:0] ItemClear = 8'h01;

  class noise_floor_scoreboard;
    int sine_rom[RomDepth];
    // configuration copy
    int unsigned gain_goal_cfg, ramp_len_cfg, hum_inc_cfg, whir_inc_cfg, am_inc_cfg;
    int unsigned age_cfg, seed_cfg;
    // block state copy
    logic [31:0] lcg;
    longint slow_pole, mid_pole, fast_pole;
    logic [23:0] hum_ph, whir_ph, am_ph;
    int gain_now, gain_seen, gain_step, ramp_left;
    logic [23:0] sample_q[$];
    int errors;

    function new();
      for (int i = 0; i < RomDepth; i++) begin
        int unsigned u, q, r, v;
        u = 4 * i;
        q = u / RomDepth;
        r = u % RomDepth;
        v = quarter_sine(q[0] ? RomDepth - r : r);
        sine_rom[i] = (q >= 2) ? -int'(v) : int'(v);
      end
      gain_goal_cfg = GainTargetRst;
      ramp_len_cfg  = RampLengthRst;
      hum_inc_cfg   = HumIncRst;
      whir_inc_cfg  = WhirIncRst;
      am_inc_cfg    = WhirAmIncRst;
      age_cfg       = AgeLevelRst;
      seed_cfg      = RngSeedRst;
      lcg = seed_cfg;
      slow_pole = 0; mid_pole = 0; fast_pole = 0;
      hum_ph = '0; whir_ph = '0; am_ph = '0;
      gain_now = gain_goal_cfg;
      gain_seen = gain_goal_cfg;
      gain_step = 0;
      ramp_left = 0;
      errors = 0;
    endfunction

    // Taylor series of sin over one quarter turn, Q1.23
    function int unsigned quarter_sine(longint unsigned m);
      longint unsigned x, x2, t, r;
      x = HalfPiQ30 * m / RomDepth;
      x2 = (x * x) >> 30;
      t = OneQ30;
      t = OneQ30 - ((x2 * t) >> 30) / 110;
      t = OneQ30 - ((x2 * t) >> 30) / 72;
      t = OneQ30 - ((x2 * t) >> 30) / 42;
      t = OneQ30 - ((x2 * t) >> 30) / 20;
      t = OneQ30 - ((x2 * t) >> 30) / 6;
      r = (((x * t) >> 30) + 64) >> 7;
      if (r > Q23Max) r = Q23Max;
      return int'(r);
    endfunction

    function longint rnd_mul(longint a, longint b, int s);
      return (a * b + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint sine_of(logic [23:0] ph);
      return sine_rom[ph[23:16]];
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_GAIN_TARGET: gain_goal_cfg = d[23:0];
        CFG_RAMP_LENGTH: ramp_len_cfg = d[15:0];
        CFG_HUM_INC:     hum_inc_cfg = d[23:0];
        CFG_WHIR_INC:    whir_inc_cfg = d[23:0];
        CFG_WHIR_AM_INC: am_inc_cfg = d[23:0];
        CFG_AGE_LEVEL:   age_cfg = d[15:0];
        CFG_RNG_SEED: begin
          seed_cfg = d;
          lcg = d;
        end
        default: ;
      endcase
    endfunction

    function void note_input(logic [7:0] d);
      longint white, pk, hiss, hum, am, wg, whir, total, g;
      logic [23:0] h2, h3;
      if (gain_goal_cfg != gain_seen) begin
        gain_seen = gain_goal_cfg;
        if (ramp_len_cfg == 0) begin
          gain_now = gain_seen;
          ramp_left = 0;
          gain_step = 0;
        end else begin
          ramp_left = ramp_len_cfg;
          gain_step = (gain_seen - gain_now) / int'(ramp_len_cfg);
        end
      end
      if (d[0]) begin
        slow_pole = 0; mid_pole = 0; fast_pole = 0;
        hum_ph = '0; whir_ph = '0; am_ph = '0;
        gain_now = gain_seen;
        ramp_left = 0;
        gain_step = 0;
        return;
      end
      lcg = lcg * LcgMul + LcgAdd;
      white = (longint'(lcg[23:8]) * 2 - 65535) * 128;
      slow_pole = clip32(rnd_mul(slow_pole, KSlowPole, 24) + rnd_mul(white, KSlowIn, 24));
      mid_pole = clip32(rnd_mul(mid_pole, KMidPole, 24) + rnd_mul(white, KMidIn, 24));
      fast_pole = clip32(rnd_mul(fast_pole, KFastPole, 24) + rnd_mul(white, KFastIn, 24));
      pk = slow_pole + mid_pole + fast_pole + rnd_mul(white, KDirect, 24);
      pk = rnd_mul(pk, KPinkOut, 24);
      if (ramp_left > 0) begin
        ramp_left--;
        if (ramp_left > 0) begin
          g = longint'(gain_now) + gain_step;
          if (g < 0) g = 0;
          if (g > 64'sh0FFFFFF) g = 64'sh0FFFFFF;
          gain_now = int'(g);
        end else begin
          gain_now = gain_seen;
        end
      end else begin
        gain_now = gain_seen;
      end
      hiss = rnd_mul(pk, gain_now, 24);
      h2 = hum_ph * 2;
      h3 = hum_ph * 3;
      hum = sine_of(hum_ph) + rnd_mul(sine_of(h2), KHarm2, 24) +
            rnd_mul(sine_of(h3), KHarm3, 24);
      hum = rnd_mul(hum, KHum, 24);
      am = (8388608 + sine_of(am_ph)) / 2;
      wg = rnd_mul(KWhir, 65536 + longint'(age_cfg), 16);
      whir = rnd_mul(rnd_mul(am, wg, 24), sine_of(whir_ph), 23);
      hum_ph = hum_ph + hum_inc_cfg[23:0];
      whir_ph = whir_ph + whir_inc_cfg[23:0];
      am_ph = am_ph + am_inc_cfg[23:0];
      total = hiss + hum + whir;
      if (total > 8388607) total = 8388607;
      if (total < -8388608) total = -8388608;
      sample_q.push_back(total[23:0]);
    endfunction

    function void check_sample(logic [23:0] got);
      logic [23:0] want;
      if (sample_q.size() == 0) begin
        $error("sample_out: no sample expected, actual %0d", $signed(got));
        errors++;
        return;
      end
      want = sample_q.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] clear_state
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [23:0] sample_out
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  noise_floor_scoreboard sb = new();
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit rx_hold = 1'b0;

  analog_noise_floor_generator dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata);
  end

  task automatic push_item(logic [7:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(d);
  endtask

  task automatic stop_items();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.sample_q.size() != 0) @(negedge clk_i);
  endtask

  // all expected samples out, then room for queued clears and the divider to finish
  task automatic drain();
    stop_items();
    wait_results();
    repeat (200) @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_item();
    logic [7:0] d;
    d = 8'($urandom);
    d[0] = ($urandom_range(99) < 8);
    return d;
  endfunction

  initial begin
    logic [31:0] v;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: reset settings, clears with stray upper bits, back-to-back samples
    push_item(ItemClear);
    push_item(ItemMake);
    push_item(ItemMake);
    push_item(8'hFF);
    push_item(8'hFE);
    push_item(ItemMake);
    push_item(ItemClear);
    push_item(ItemMake);
    drain();

    // upper extremes, zero ramp length snaps the gain
    write_reg(CFG_GAIN_TARGET, 32'hFFFF_FFFF);
    write_reg(CFG_RAMP_LENGTH, 32'h0000_0000);
    write_reg(CFG_HUM_INC, 32'h00FF_FFFF);
    write_reg(CFG_WHIR_INC, 32'h00FF_FFFF);
    write_reg(CFG_WHIR_AM_INC, 32'h00FF_FFFF);
    write_reg(CFG_AGE_LEVEL, 32'h0000_FFFF);
    write_reg(CFG_RNG_SEED, 32'hFFFF_FFFF);
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    repeat (5) push_item(ItemMake);
    drain();

    // lower extremes, ramp down, then a clear in the middle of a ramp
    write_reg(CFG_GAIN_TARGET, 32'h0);
    write_reg(CFG_RAMP_LENGTH, 32'd4);
    write_reg(CFG_HUM_INC, 32'h0);
    write_reg(CFG_WHIR_INC, 32'h0);
    write_reg(CFG_WHIR_AM_INC, 32'h0);
    write_reg(CFG_AGE_LEVEL, 32'h0);
    write_reg(CFG_RNG_SEED, 32'h0);
    repeat (5) push_item(ItemMake);
    drain();
    write_reg(CFG_GAIN_TARGET, 32'h00FF_FFFF);
    write_reg(CFG_RAMP_LENGTH, 32'd65535);
    push_item(ItemMake);
    push_item(ItemClear);
    push_item(ItemMake);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 12; rx_idle_pct = 81;
      end else if (ph < 6) begin
        tx_idle_pct = 81; rx_idle_pct = 12;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      v = (ph % 3 == 0) ? 32'hFFFF_FFFF : (ph % 3 == 1) ? 32'h0 : $urandom;
      write_reg(CFG_GAIN_TARGET, (ph % 3 == 2) ? $urandom : v);
      write_reg(CFG_RAMP_LENGTH, (ph == 7) ? 32'd65535 : $urandom_range(300));
      write_reg(CFG_HUM_INC, (ph % 2) ? $urandom : $urandom_range(200000));
      write_reg(CFG_WHIR_INC, (ph % 2) ? $urandom : $urandom_range(200000));
      write_reg(CFG_WHIR_AM_INC, $urandom);
      write_reg(CFG_AGE_LEVEL, (ph % 3 == 2) ? $urandom : v);
      write_reg(CFG_RNG_SEED, $urandom);
      if (ph == 1) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(negedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 200; n++) begin
        if (ph == 4 && n == 100) begin
          stop_items();
          wait_results();
        end
        // on even phases, a gain change after 120 items keeps the ramp logic busy inside a phase
        if (n == 120 && ph % 2 == 0) begin
          drain();
          write_reg(CFG_GAIN_TARGET, $urandom);
        end
        push_item(random_item());
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.sample_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
